FILE: hw/rtl/b32ad_pkg.sv
// ----------------------------------------------------------------------------
// b32ad_pkg
// Shared types, constants and functions of the bech32 address decoder.
// ----------------------------------------------------------------------------
package b32ad_pkg;

	localparam int PREFIX_MAX_DEF = 16;

	localparam logic [7:0] SEP_CHAR = 8'h31;

	localparam int CS_W = 30;
	localparam logic [CS_W-1:0] CS_INIT = 30'd1;
	localparam logic [CS_W-1:0] GEN [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	localparam int DELAY_DEPTH = 6;
	localparam logic [2:0] DELAY_FULL = 3'd6;
	localparam logic [7:0] MIN_SYMS = 8'd6;
	localparam logic [7:0] SYM_SAT = 8'hFF;
	localparam logic [5:0] BYTE_SAT = 6'd63;
	localparam logic [5:0] PROG_LEN_A = 6'd20;
	localparam logic [5:0] PROG_LEN_B = 6'd32;
	localparam logic [3:0] SYM_BITS = 4'd5;
	localparam logic [3:0] BYTE_BITS = 4'd8;

	localparam logic [7:0] CHARSET [32] = '{
		"q", "p", "z", "r", "y", "9", "x", "8", "g", "f", "2", "t", "v", "d", "w", "0",
		"s", "3", "j", "n", "5", "4", "k", "h", "c", "e", "6", "m", "u", "a", "7", "l"
	};

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SEP  = 3'd1,
		ST_SHORT    = 3'd2,
		ST_BAD_CHAR = 3'd3,
		ST_BAD_CSUM = 3'd4,
		ST_EMPTY    = 3'd5,
		ST_LEFTOVER = 3'd6,
		ST_BAD_LEN  = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		FOLD_NONE,
		FOLD_PRIME,
		FOLD_HI,
		FOLD_ZERO,
		FOLD_LO
	} fold_op_t;

	typedef struct packed {
		logic     step;
		fold_op_t fold_op;
		logic     load_status;
	} dp_cmd_t;

	typedef struct packed {
		logic need_fold;
		logic has_byte;
		logic fin;
		logic fold_last;
	} dp_sts_t;

	// one step of the BCH polymod
	function automatic logic [CS_W-1:0] poly_step(input logic [CS_W-1:0] c);
		logic [CS_W-1:0] r;
		r = {c[24:0], 5'b00000};
		for (int i = 0; i < 5; i++) begin
			if (c[25+i]) begin
				r = r ^ GEN[i];
			end
		end
		return r;
	endfunction

	// {hit, value}
	function automatic logic [5:0] sym_lookup(input logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (c == CHARSET[i]) begin
				r = {1'b1, 5'(i)};
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/b32ad_if.sv
// ----------------------------------------------------------------------------
// b32ad_if
// Valid/ready channels of the decoder: character beats in, result beats out.
// ----------------------------------------------------------------------------
interface b32ad_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_final;

	modport source(output valid, char_code, is_final, input ready);
	modport sink(input valid, char_code, is_final, output ready);
endinterface

interface b32ad_res_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] data_byte;
	logic       done_res;
	logic [2:0] status;

	modport source(output valid, has_byte, data_byte, done_res, status, input ready);
	modport sink(input valid, has_byte, data_byte, done_res, status, output ready);
endinterface

FILE: hw/rtl/b32ad_dp.sv
// ----------------------------------------------------------------------------
// b32ad_dp
// Datapath: prefix memory, checksum, symbol delay line, 5-to-8 repacking,
// status evaluation and the output beat register.
// ----------------------------------------------------------------------------
module b32ad_dp #(
	parameter int PREFIX_MAX = b32ad_pkg::PREFIX_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_code,
	input  logic                is_final,
	input  b32ad_pkg::dp_cmd_t  cmd,
	output b32ad_pkg::dp_sts_t  sts,
	output logic                has_byte,
	output logic [7:0]          data_byte,
	output logic                done_res,
	output logic [2:0]          status
);

	localparam int PCW = $clog2(PREFIX_MAX + 2);
	localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
	localparam logic [PCW-1:0] PM_C = PCW'(PREFIX_MAX);
	localparam int CW = b32ad_pkg::CS_W;

	logic [7:0]     pfx_mem [PREFIX_MAX];
	logic [7:0]     rd_q;

	logic           in_data_q, n_in_data;
	logic [PCW-1:0] pfx_cnt_q, n_pfx_cnt;
	logic [PCW-1:0] fold_idx_q;
	logic [CW-1:0]  cs_q, n_cs;
	logic [4:0]     dly_q [b32ad_pkg::DELAY_DEPTH];
	logic [2:0]     fill_q, n_fill;
	logic           vskip_q, n_vskip;
	logic [7:0]     sym_cnt_q, n_sym_cnt;
	logic [11:0]    acc_q, n_acc;
	logic [3:0]     bc_q, n_bc;
	logic [5:0]     byte_cnt_q, n_byte_cnt;
	logic           cerr_q, n_cerr;

	logic [5:0]     sym;
	logic           pfx_wr;
	logic           dly_shift;
	logic           byte_c;
	logic [7:0]     byte_val;
	logic           need_fold_c;
	logic [3:0]     bc5;
	b32ad_pkg::status_t st_c;
	b32ad_pkg::status_t st_q;

	logic           out_has_q;
	logic [7:0]     out_byte_q;
	logic           out_done_q;
	b32ad_pkg::status_t out_st_q;

	always_comb begin
		sym         = b32ad_pkg::sym_lookup(char_code);
		n_in_data   = in_data_q;
		n_pfx_cnt   = pfx_cnt_q;
		n_cs        = cs_q;
		n_fill      = fill_q;
		n_vskip     = vskip_q;
		n_sym_cnt   = sym_cnt_q;
		n_acc       = acc_q;
		n_bc        = bc_q;
		n_byte_cnt  = byte_cnt_q;
		n_cerr      = cerr_q;
		pfx_wr      = 1'b0;
		dly_shift   = 1'b0;
		byte_c      = 1'b0;
		byte_val    = 8'd0;
		need_fold_c = 1'b0;
		bc5         = bc_q + b32ad_pkg::SYM_BITS;
		if (!in_data_q) begin
			if (char_code == b32ad_pkg::SEP_CHAR) begin
				n_in_data   = 1'b1;
				need_fold_c = (pfx_cnt_q != '0) && (pfx_cnt_q <= PM_C) && !is_final;
			end else if (pfx_cnt_q < PM_C) begin
				pfx_wr    = 1'b1;
				n_pfx_cnt = pfx_cnt_q + 1'b1;
			end else begin
				n_pfx_cnt = PM_C + 1'b1;
			end
		end else begin
			if (sym_cnt_q != b32ad_pkg::SYM_SAT) begin
				n_sym_cnt = sym_cnt_q + 8'd1;
			end
			if (!sym[5]) begin
				n_cerr = 1'b1;
			end else begin
				n_cs      = b32ad_pkg::poly_step(cs_q) ^ {25'd0, sym[4:0]};
				dly_shift = 1'b1;
				if (fill_q == b32ad_pkg::DELAY_FULL) begin
					if (!vskip_q) begin
						n_vskip = 1'b1;
					end else begin
						n_acc = {acc_q[6:0], dly_q[b32ad_pkg::DELAY_DEPTH-1]};
						if (bc5 >= b32ad_pkg::BYTE_BITS) begin
							n_bc     = bc5 - b32ad_pkg::BYTE_BITS;
							byte_c   = 1'b1;
							byte_val = 8'(n_acc >> n_bc);
							if (byte_cnt_q != b32ad_pkg::BYTE_SAT) begin
								n_byte_cnt = byte_cnt_q + 6'd1;
							end
						end else begin
							n_bc = bc5;
						end
					end
				end else begin
					n_fill = fill_q + 3'd1;
				end
			end
		end

		if (!n_in_data || n_pfx_cnt == '0 || n_sym_cnt == 8'd0) begin
			st_c = b32ad_pkg::ST_BAD_SEP;
		end else if (n_sym_cnt < b32ad_pkg::MIN_SYMS) begin
			st_c = b32ad_pkg::ST_SHORT;
		end else if (n_cerr) begin
			st_c = b32ad_pkg::ST_BAD_CHAR;
		end else if (n_pfx_cnt > PM_C) begin
			st_c = b32ad_pkg::ST_BAD_LEN;
		end else if (n_cs != b32ad_pkg::CS_INIT) begin
			st_c = b32ad_pkg::ST_BAD_CSUM;
		end else if (n_sym_cnt == b32ad_pkg::MIN_SYMS) begin
			st_c = b32ad_pkg::ST_EMPTY;
		end else if (n_bc >= b32ad_pkg::SYM_BITS) begin
			st_c = b32ad_pkg::ST_LEFTOVER;
		end else if (n_byte_cnt != b32ad_pkg::PROG_LEN_A
				&& n_byte_cnt != b32ad_pkg::PROG_LEN_B) begin
			st_c = b32ad_pkg::ST_BAD_LEN;
		end else begin
			st_c = b32ad_pkg::ST_OK;
		end
	end

	assign sts.need_fold = need_fold_c;
	assign sts.has_byte  = byte_c;
	assign sts.fin       = is_final;
	assign sts.fold_last = (fold_idx_q == pfx_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_data_q  <= 1'b0;
			pfx_cnt_q  <= '0;
			fold_idx_q <= '0;
			cs_q       <= b32ad_pkg::CS_INIT;
			fill_q     <= 3'd0;
			vskip_q    <= 1'b0;
			sym_cnt_q  <= 8'd0;
			acc_q      <= 12'd0;
			bc_q       <= 4'd0;
			byte_cnt_q <= 6'd0;
			cerr_q     <= 1'b0;
		end else if (cmd.step) begin
			if (is_final) begin
				in_data_q  <= 1'b0;
				pfx_cnt_q  <= '0;
				cs_q       <= b32ad_pkg::CS_INIT;
				fill_q     <= 3'd0;
				vskip_q    <= 1'b0;
				sym_cnt_q  <= 8'd0;
				acc_q      <= 12'd0;
				bc_q       <= 4'd0;
				byte_cnt_q <= 6'd0;
				cerr_q     <= 1'b0;
			end else begin
				in_data_q  <= n_in_data;
				pfx_cnt_q  <= n_pfx_cnt;
				fill_q     <= n_fill;
				vskip_q    <= n_vskip;
				sym_cnt_q  <= n_sym_cnt;
				acc_q      <= n_acc;
				bc_q       <= n_bc;
				byte_cnt_q <= n_byte_cnt;
				cerr_q     <= n_cerr;
				if (need_fold_c) begin
					cs_q       <= b32ad_pkg::CS_INIT;
					fold_idx_q <= '0;
				end else begin
					cs_q <= n_cs;
				end
			end
		end else begin
			unique case (cmd.fold_op)
				b32ad_pkg::FOLD_NONE: begin
				end
				b32ad_pkg::FOLD_PRIME: begin
					fold_idx_q <= fold_idx_q + 1'b1;
				end
				b32ad_pkg::FOLD_HI: begin
					cs_q <= b32ad_pkg::poly_step(cs_q) ^ {27'd0, rd_q[7:5]};
					fold_idx_q <= sts.fold_last ? '0 : fold_idx_q + 1'b1;
				end
				b32ad_pkg::FOLD_ZERO: begin
					cs_q       <= b32ad_pkg::poly_step(cs_q);
					fold_idx_q <= fold_idx_q + 1'b1;
				end
				b32ad_pkg::FOLD_LO: begin
					cs_q <= b32ad_pkg::poly_step(cs_q) ^ {25'd0, rd_q[4:0]};
					fold_idx_q <= fold_idx_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// prefix memory, delay line and result payload
	always_ff @(posedge clk) begin
		if (cmd.step && pfx_wr) begin
			pfx_mem[pfx_cnt_q[AW-1:0]] <= char_code;
		end
		if (cmd.fold_op != b32ad_pkg::FOLD_NONE && fold_idx_q < PM_C) begin
			rd_q <= pfx_mem[fold_idx_q[AW-1:0]];
		end
		if (cmd.step && dly_shift) begin
			dly_q[0] <= sym[4:0];
			for (int i = 1; i < b32ad_pkg::DELAY_DEPTH; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
		if (cmd.step && is_final) begin
			st_q <= st_c;
		end
		if (cmd.step && byte_c) begin
			out_has_q  <= 1'b1;
			out_byte_q <= byte_val;
			out_done_q <= 1'b0;
			out_st_q   <= b32ad_pkg::ST_OK;
		end else if (cmd.step && is_final) begin
			out_has_q  <= 1'b0;
			out_byte_q <= 8'd0;
			out_done_q <= 1'b1;
			out_st_q   <= st_c;
		end else if (cmd.load_status) begin
			out_has_q  <= 1'b0;
			out_byte_q <= 8'd0;
			out_done_q <= 1'b1;
			out_st_q   <= st_q;
		end
	end

	assign has_byte  = out_has_q;
	assign data_byte = out_byte_q;
	assign done_res  = out_done_q;
	assign status    = out_st_q;

endmodule

FILE: hw/rtl/b32ad_ctrl.sv
// ----------------------------------------------------------------------------
// b32ad_ctrl
// Controller: input handshake, prefix fold sequencing, output beat valid and
// the pending status beat.
// ----------------------------------------------------------------------------
module b32ad_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  b32ad_pkg::dp_sts_t sts,
	output b32ad_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_RUN,
		S_PRIME,
		S_HI,
		S_ZERO,
		S_LO
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   pend_q;
	logic   slot_free;
	logic   step;
	logic   load_status;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_RUN) && !pend_q && slot_free;
	assign step        = in_valid && in_ready;
	assign load_status = pend_q && slot_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		cmd.step        = step;
		cmd.load_status = load_status;
		unique case (state_q)
			S_RUN:   cmd.fold_op = b32ad_pkg::FOLD_NONE;
			S_PRIME: cmd.fold_op = b32ad_pkg::FOLD_PRIME;
			S_HI:    cmd.fold_op = b32ad_pkg::FOLD_HI;
			S_ZERO:  cmd.fold_op = b32ad_pkg::FOLD_ZERO;
			S_LO:    cmd.fold_op = b32ad_pkg::FOLD_LO;
			default: cmd.fold_op = b32ad_pkg::FOLD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if ((step && (sts.has_byte || sts.fin)) || load_status) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (load_status) begin
				pend_q <= 1'b0;
			end else if (step && sts.has_byte && sts.fin) begin
				pend_q <= 1'b1;
			end

			unique case (state_q)
				S_RUN: begin
					if (step && sts.need_fold) begin
						state_q <= S_PRIME;
					end
				end
				S_PRIME: state_q <= S_HI;
				S_HI: begin
					if (sts.fold_last) begin
						state_q <= S_ZERO;
					end
				end
				S_ZERO: state_q <= S_LO;
				S_LO: begin
					if (sts.fold_last) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule

FILE: hw/rtl/bech32_address_decode.sv
// ----------------------------------------------------------------------------
// bech32_address_decode
// Streaming bech32 segwit address decoder, one character per beat.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle unless a prefix fold, a pending status
// or a full output register holds the input. The separator of an address
// with an N-character prefix (1 <= N <= PREFIX_MAX) starts a fold in which
// the prefix is read back from its memory and folded into the checksum (high
// bits, a zero step, then low bits); no character is taken meanwhile. Each
// data character may give one provisional program byte; the final character
// gives a status beat (after the byte beat, if any). A single output register
// holds the next result beat; input stalls while it is full and not being taken.
module bech32_address_decode #(
	parameter int PREFIX_MAX = b32ad_pkg::PREFIX_MAX_DEF
) (
	input logic         clk,
	input logic         arst_n,
	b32ad_char_if.sink  chars,
	b32ad_res_if.source results
);

	b32ad_pkg::dp_cmd_t cmd;
	b32ad_pkg::dp_sts_t sts;

	b32ad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	b32ad_dp #(
		.PREFIX_MAX(PREFIX_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (chars.char_code),
		.is_final  (chars.is_final),
		.cmd       (cmd),
		.sts       (sts),
		.has_byte  (results.has_byte),
		.data_byte (results.data_byte),
		.done_res  (results.done_res),
		.status    (results.status)
	);

endmodule
